### rtl/core/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// shared types and constants of the integer to text formatter
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int OUT_MAX     = 64;
    localparam int DIGIT_DEPTH = 64;
    localparam int DIG_AW      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // output character source selects
    localparam logic [2:0] SEL_SPACE = 3'd0;
    localparam logic [2:0] SEL_SIGN  = 3'd1;
    localparam logic [2:0] SEL_ZERO  = 3'd2;
    localparam logic [2:0] SEL_X     = 3'd3;
    localparam logic [2:0] SEL_DIGIT = 3'd4;
    localparam logic [2:0] SEL_BAD   = 3'd5;

    typedef struct packed {
        logic       load;       // capture the item
        logic       div_start;  // start one digit division
        logic       dig_rd;     // read one digit from the store
        logic       out_load;   // present a character
        logic [2:0] out_sel;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic             div_done;
        logic             val_zero;   // quotient is zero
        logic [CNT_W-1:0] nd;         // digits found
        logic             bad;
        logic             left;
        logic             zpad;
        logic             has_sign;
        logic [1:0]       prefix_len;
        logic [6:0]       fw;
        logic [6:0]       prec;
        logic [6:0]       room;
    } t_stat;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
        logic [7:0] c;
        if (d < 6'd10) c = CH_ZERO + {2'b00, d};
        else if (lower) c = 8'h61 + {2'b00, d} - 8'd10;
        else c = 8'h41 + {2'b00, d} - 8'd10;
        return c;
    endfunction

endpackage

### rtl/core/itf_datapath.sv
// ----------------------------------------------------------------------------
// itf_datapath
// item registers, bit-serial divider, digit store and output register
// ----------------------------------------------------------------------------
module itf_datapath
    import itf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_radix,
    input  logic [6:0]  i_min_width,
    input  logic [6:0]  i_precision,
    input  logic        i_left_align,
    input  logic        i_zero_pad,
    input  logic        i_signed_mode,
    input  logic        i_plus_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_prefix,
    input  logic        i_lower_case,
    input  logic [6:0]  i_room,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    output logic        o_bad_base
);

    logic [63:0]      r_quo;
    logic [63:0]      r_num;
    logic [5:0]       r_rem;
    logic [6:0]       r_bit;
    logic             r_busy;
    logic [5:0]       r_radix;
    logic             r_lower;
    logic [7:0]       r_sign_ch;
    logic [CNT_W-1:0] r_nd;
    logic [DIG_AW-1:0] r_rd_ptr;
    logic [5:0]       r_dig_q;
    logic             r_bad;
    logic             r_left;
    logic             r_zpad;
    logic [1:0]       r_prefix_len;
    logic [6:0]       r_fw;
    logic [6:0]       r_prec;
    logic [6:0]       r_room;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_last;
    logic             r_bad_out;
    logic             r_done;

    logic [5:0] mem [DIGIT_DEPTH];

    logic        neg;
    logic [6:0]  trial;
    logic [7:0]  n_char;
    logic [CNT_W-1:0] nd_inc;

    assign neg    = i_signed_mode & i_value[63];
    assign trial  = {r_rem, r_num[63]};
    assign nd_inc = r_nd + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load) begin
                r_quo        <= neg ? 64'd0 - i_value : i_value;
                r_radix      <= i_radix;
                r_lower      <= i_lower_case;
                r_bad        <= (i_radix < 6'd2) || (i_radix > 6'd36);
                r_left       <= i_left_align;
                r_zpad       <= i_zero_pad & ~i_left_align;
                r_sign_ch    <= neg ? CH_MINUS :
                                (i_signed_mode & i_plus_sign) ? CH_PLUS :
                                (i_signed_mode & i_space_sign) ? CH_SPACE : 8'd0;
                r_prefix_len <= !i_alt_prefix ? 2'd0 : (i_radix == 6'd8) ? 2'd1 :
                                (i_radix == 6'd16) ? 2'd2 : 2'd0;
                r_fw         <= (i_min_width > 7'd64) ? 7'd64 : i_min_width;
                r_prec       <= (i_precision > 7'd64) ? 7'd64 : i_precision;
                r_room       <= (i_room > 7'(OUT_MAX)) ? 7'(OUT_MAX) : i_room;
                r_nd         <= '0;
                r_rd_ptr     <= '0;
            end
            // restoring division, one quotient bit a cycle
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                // a follow-on division starts from the quotient just found
                r_num  <= r_done ? r_num : r_quo;
                r_rem  <= '0;
                r_bit  <= 7'd64;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_radix}) begin
                    r_rem <= 6'(trial - {1'b0, r_radix});
                    r_num <= {r_num[62:0], 1'b1};
                end else begin
                    r_rem <= trial[5:0];
                    r_num <= {r_num[62:0], 1'b0};
                end
                r_bit <= r_bit - 7'd1;
                if (r_bit == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_done) begin
                r_quo    <= r_num;
                r_nd     <= nd_inc;
                // read pointer sits one above the most significant digit
                r_rd_ptr <= nd_inc[DIG_AW-1:0];
            end
            if (i_cmd.dig_rd) begin
                r_rd_ptr <= r_rd_ptr - DIG_AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_char  <= n_char;
                r_last      <= i_cmd.out_last;
                r_bad_out   <= (i_cmd.out_sel == SEL_BAD);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit store: written with each remainder, read most significant first
    always_ff @(posedge i_clk) begin
        if (r_done) begin
            mem[r_nd[DIG_AW-1:0]] <= r_rem;
        end
        if (i_cmd.dig_rd) begin
            r_dig_q <= mem[r_rd_ptr - DIG_AW'(1)];
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            SEL_SPACE: n_char = CH_SPACE;
            SEL_SIGN:  n_char = r_sign_ch;
            SEL_ZERO:  n_char = CH_ZERO;
            SEL_X:     n_char = r_lower ? CH_X_LO : CH_X_UP;
            SEL_DIGIT: n_char = digit_char(r_dig_q, r_lower);
            default:   n_char = 8'd0;
        endcase
    end

    always_comb begin
        o_stat.div_done   = r_done;
        o_stat.val_zero   = (r_num == 64'd0);
        o_stat.nd         = r_nd + CNT_W'(r_done);
        o_stat.bad        = r_bad;
        o_stat.left       = r_left;
        o_stat.zpad       = r_zpad;
        o_stat.has_sign   = (r_sign_ch != 8'd0);
        o_stat.prefix_len = r_prefix_len;
        o_stat.fw         = r_fw;
        o_stat.prec       = r_prec;
        o_stat.room       = r_room;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;
    assign o_bad_base  = r_bad_out;

endmodule

### rtl/core/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl
// sequencer: digit extraction, then the character run one slot at a time
// ----------------------------------------------------------------------------
module itf_ctrl
    import itf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    input  logic  i_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PLAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // run phases
    localparam logic [2:0] PH_LPAD = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_PRE0 = 3'd2;
    localparam logic [2:0] PH_PREX = 3'd3;
    localparam logic [2:0] PH_ZERO = 3'd4;
    localparam logic [2:0] PH_DIG  = 3'd5;
    localparam logic [2:0] PH_RPAD = 3'd6;
    localparam logic [2:0] PH_END  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ph, n_ph;
    logic [6:0] r_cnt, n_cnt;      // characters left in the phase
    logic [6:0] r_left, n_left;    // characters still to send
    logic [6:0] r_pad, n_pad;
    logic [6:0] r_zeros, n_zeros;
    logic       r_rd_pend, n_rd_pend;

    logic [7:0] head;
    logic [7:0] total;
    logic [6:0] body;
    logic [6:0] nd7;
    logic       slot_free;

    assign nd7  = 7'(i_stat.nd);
    assign body = (i_stat.prec > nd7) ? i_stat.prec : nd7;
    assign head = {1'b0, body} + 8'(i_stat.has_sign) + {6'd0, i_stat.prefix_len};
    // full text length: the width when it is wider than the content
    assign total = (8'(i_stat.fw) > head) ? 8'(i_stat.fw) : head;
    assign slot_free = !i_out_valid || i_out_ready;

    // length of a phase
    function automatic logic [6:0] ph_len(input logic [2:0] ph, input t_stat s,
                                          input logic [6:0] pad, input logic [6:0] zs,
                                          input logic [6:0] n);
        logic [6:0] l;
        case (ph)
            PH_LPAD: l = (!s.left && !s.zpad) ? pad : 7'd0;
            PH_SIGN: l = 7'(s.has_sign);
            PH_PRE0: l = (s.prefix_len != 2'd0) ? 7'd1 : 7'd0;
            PH_PREX: l = (s.prefix_len == 2'd2) ? 7'd1 : 7'd0;
            PH_ZERO: l = zs;
            PH_DIG:  l = n;
            PH_RPAD: l = s.left ? pad : 7'd0;
            default: l = 7'd0;
        endcase
        return l;
    endfunction

    always_comb begin
        n_state   = r_state;
        n_ph      = r_ph;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_pad     = r_pad;
        n_zeros   = r_zeros;
        n_rd_pend = 1'b0;
        o_cmd     = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.bad) begin
                    if (slot_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = SEL_BAD;
                        o_cmd.out_last = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.val_zero || i_stat.nd == CNT_W'(DIGIT_DEPTH)) begin
                        n_state = ST_PLAN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end
            end
            ST_PLAN: begin
                n_pad   = (8'(i_stat.fw) > head) ? 7'(8'(i_stat.fw) - head) : 7'd0;
                // zero fill and precision zeros run together
                n_zeros = (body - nd7) + (i_stat.zpad ? n_pad : 7'd0);
                n_left  = ({1'b0, i_stat.room} < total) ? i_stat.room : 7'(total);
                n_ph    = PH_LPAD;
                n_cnt   = ph_len(PH_LPAD, i_stat, n_pad, n_zeros, nd7);
                n_state = (i_stat.room == 7'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (r_cnt == 7'd0) begin
                    // move to the next phase
                    if (r_ph == PH_RPAD) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ph  = r_ph + 3'd1;
                        n_cnt = ph_len(r_ph + 3'd1, i_stat, r_pad, r_zeros, nd7);
                        if (r_ph + 3'd1 == PH_DIG) begin
                            o_cmd.dig_rd = 1'b1;
                            n_rd_pend = 1'b1;
                        end
                    end
                end else if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                end else if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    case (r_ph)
                        PH_SIGN: o_cmd.out_sel = SEL_SIGN;
                        PH_PRE0: o_cmd.out_sel = SEL_ZERO;
                        PH_PREX: o_cmd.out_sel = SEL_X;
                        PH_ZERO: o_cmd.out_sel = SEL_ZERO;
                        PH_DIG:  o_cmd.out_sel = SEL_DIGIT;
                        default: o_cmd.out_sel = SEL_SPACE;
                    endcase
                    n_cnt  = r_cnt - 7'd1;
                    n_left = r_left - 7'd1;
                    // final character, either end of text or out of room
                    if (r_left == 7'd1) begin
                        o_cmd.out_last = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_ph == PH_DIG && r_cnt != 7'd1) begin
                        o_cmd.dig_rd = 1'b1;
                        n_rd_pend = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
        r_ph    <= n_ph;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_pad   <= n_pad;
        r_zeros <= n_zeros;
    end

endmodule

### rtl/core/integer_to_text_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter_core
// printf style integer conversion, one ascii character per result item
// ----------------------------------------------------------------------------
// sequence: a bad base goes through the check state and the output register;
//   else each digit takes 64 quotient bits in the serial divider and a hand-over
// items: one item at a time, a new item is taken only in the idle state
// reset: synchronous active low, clears controller state and output valid
// ----------------------------------------------------------------------------
module integer_to_text_formatter_core
    import itf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_radix,
    input  logic [6:0]  i_min_width,
    input  logic [6:0]  i_precision,
    input  logic        i_left_align,
    input  logic        i_zero_pad,
    input  logic        i_signed_mode,
    input  logic        i_plus_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_prefix,
    input  logic        i_lower_case,
    input  logic [6:0]  i_room,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    output logic        o_bad_base
);

    t_cmd  cmd;
    t_stat stat;
    logic  dp_valid;
    logic  dp_last;

    // controller walks the phases, datapath holds digits and the output item
    itf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_out_valid (dp_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    itf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_min_width   (i_min_width),
        .i_precision   (i_precision),
        .i_left_align  (i_left_align),
        .i_zero_pad    (i_zero_pad),
        .i_signed_mode (i_signed_mode),
        .i_plus_sign   (i_plus_sign),
        .i_space_sign  (i_space_sign),
        .i_alt_prefix  (i_alt_prefix),
        .i_lower_case  (i_lower_case),
        .i_room        (i_room),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (dp_valid),
        .o_out_char    (o_out_char),
        .o_last        (dp_last),
        .o_bad_base    (o_bad_base)
    );

    assign o_out_valid = dp_valid;
    assign o_last      = dp_last;

endmodule
